>>> sv/ps2_mouse_packet_tracker_macros.svh
// Assertion macros for the ps2 mouse packet tracker checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PS2_MOUSE_PACKET_TRACKER_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_MACROS_SVH

// Implication in the same cycle; disabled during reset.
`define PS2MT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle; disabled during reset.
`define PS2MT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle right after reset.
`define PS2MT_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> sv/ps2mt_pkg.sv
// Shared types and constants for the ps2 mouse packet tracker.
// No dependencies.
`timescale 1ns / 1ps

package ps2mt_pkg;

  localparam int PktDepth = 2;
  localparam int ResDepth = 2;

  localparam int CoordW = 8;

  // register indexes on the write port
  localparam logic RegWidthLimit  = 1'b0;
  localparam logic RegHeightLimit = 1'b1;

  localparam logic [CoordW-1:0] WidthLimitReset  = 8'd80;
  localparam logic [CoordW-1:0] HeightLimitReset = 8'd24;

  // position of a byte inside the three-byte packet
  localparam logic [1:0] ByteButtons = 2'd0;
  localparam logic [1:0] ByteDx      = 2'd1;
  localparam logic [1:0] ByteDy      = 2'd2;

  typedef struct packed {
    logic       aux_ready;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [CoordW-1:0] old_x;
    logic [CoordW-1:0] old_y;
    logic [CoordW-1:0] new_x;
    logic [CoordW-1:0] new_y;
    logic [2:0]        button_bits;
    logic [2:0]        button_changed;
  } out_item_t;

  // status of a queue as seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/ps2mt_fifo.sv
// Small synchronous queue used between front, back and the result port.
// Depends on ps2mt_pkg for the status struct.
`timescale 1ns / 1ps

module ps2mt_fifo #(
  parameter type item_t = logic [7:0],
  parameter int  DEPTH  = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  item_t                wdata,
  input  logic                 rd,
  output item_t                rdata,
  output ps2mt_pkg::q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/ps2mt_front.sv
// Front end: takes controller reads, drops non-mouse bytes and gathers
// three-byte packets. Depends on ps2mt_pkg.
`timescale 1ns / 1ps

module ps2mt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ps2mt_pkg::in_item_t item,
  output logic                pkt_valid,
  output ps2mt_pkg::pkt_t     pkt
);

  logic [1:0] byte_index;
  logic [1:0] byte_index_next;
  logic [2:0] buttons;
  logic [7:0] dx;
  logic       take;

  assign take = accept && item.aux_ready;

  always_comb begin
    byte_index_next = byte_index;
    pkt_valid       = 1'b0;
    case (byte_index)
      ps2mt_pkg::ByteButtons: byte_index_next = ps2mt_pkg::ByteDx;
      ps2mt_pkg::ByteDx:      byte_index_next = ps2mt_pkg::ByteDy;
      ps2mt_pkg::ByteDy: begin
        byte_index_next = ps2mt_pkg::ByteButtons;
        pkt_valid       = take;
      end
      default:                byte_index_next = ps2mt_pkg::ByteDx; // acts as byte 0
    endcase
  end

  assign pkt.buttons = buttons;
  assign pkt.dx      = dx;
  assign pkt.dy      = item.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= ps2mt_pkg::ByteButtons;
    end else if (take) begin
      byte_index <= byte_index_next;
    end
  end

  // packet bytes: no reset, always written before use
  always_ff @(posedge clk) begin
    if (take) begin
      if (byte_index == ps2mt_pkg::ByteButtons || byte_index == 2'd3) begin
        buttons <= item.data_byte[2:0];
      end
      if (byte_index == ps2mt_pkg::ByteDx) begin
        dx <= item.data_byte;
      end
    end
  end

endmodule

>>> sv/ps2mt_back.sv
// Back end: applies one packet to the cursor with clamping and builds the
// result. Holds the limit registers. Depends on ps2mt_pkg.
`timescale 1ns / 1ps

module ps2mt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [7:0]           wr_data,
  input  logic                 pkt_avail,
  input  ps2mt_pkg::pkt_t      pkt,
  input  logic                 res_full,
  output logic                 pkt_take,
  output ps2mt_pkg::out_item_t res
);

  logic [ps2mt_pkg::CoordW-1:0] width_limit;
  logic [ps2mt_pkg::CoordW-1:0] height_limit;
  logic [ps2mt_pkg::CoordW-1:0] cursor_x;
  logic [ps2mt_pkg::CoordW-1:0] cursor_y;
  logic [2:0]                   last_buttons;

  logic signed [9:0] sum_x;
  logic signed [9:0] sum_y;
  logic [7:0]        top_x;
  logic [7:0]        top_y;
  logic [7:0]        new_x;
  logic [7:0]        new_y;

  assign pkt_take = pkt_avail && !res_full;

  // a limit of zero behaves as one
  assign top_x = (width_limit == '0) ? '0 : width_limit - 1'b1;
  assign top_y = (height_limit == '0) ? '0 : height_limit - 1'b1;

  assign sum_x = $signed({2'b00, cursor_x}) + 10'($signed(pkt.dx));
  assign sum_y = $signed({2'b00, cursor_y}) - 10'($signed(pkt.dy));

  always_comb begin
    if (sum_x < 0) begin
      new_x = '0;
    end else if (sum_x > $signed({2'b00, top_x})) begin
      new_x = top_x;
    end else begin
      new_x = sum_x[7:0];
    end
    if (sum_y < 0) begin
      new_y = '0;
    end else if (sum_y > $signed({2'b00, top_y})) begin
      new_y = top_y;
    end else begin
      new_y = sum_y[7:0];
    end
  end

  assign res.old_x          = cursor_x;
  assign res.old_y          = cursor_y;
  assign res.new_x          = new_x;
  assign res.new_y          = new_y;
  assign res.button_bits    = pkt.buttons;
  assign res.button_changed = pkt.buttons ^ last_buttons;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_limit  <= ps2mt_pkg::WidthLimitReset;
      height_limit <= ps2mt_pkg::HeightLimitReset;
      cursor_x     <= '0;
      cursor_y     <= '0;
      last_buttons <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          ps2mt_pkg::RegWidthLimit:  width_limit  <= wr_data;
          ps2mt_pkg::RegHeightLimit: height_limit <= wr_data;
          default:                   width_limit  <= width_limit;
        endcase
      end
      if (pkt_take) begin
        cursor_x     <= new_x;
        cursor_y     <= new_y;
        last_buttons <= pkt.buttons;
      end
    end
  end

endmodule

>>> sv/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker: byte intake, cursor update, result queue.
// Depends on ps2mt_pkg, ps2mt_front, ps2mt_fifo and ps2mt_back.
//
// Input side: one controller read per request (aux_ready, data_byte), taken
// when push is high and full is low. Reads with aux_ready clear are dropped.
// Mouse bytes are gathered in threes; the third byte of a packet completes a
// packet that goes into a short packet queue.
// Back end: takes one packet per cycle while the result queue has room, moves
// the cursor (x plus byte 1, y minus byte 2, each clamped to 0..limit-1) and
// pushes one result request into the result queue. Results are read with empty/pop.
// A packet's third byte puts the packet into the packet queue as it is
// accepted; the back end then pushes its result into the result queue, where
// it shows with empty low. Throughput: one byte per cycle while full is low.
// Stalls: if pop is held low, the result queue fills, then the packet queue,
// and full rises; bytes are never dropped. The user must write limits on
// wr_en/wr_index/wr_data only while the block is idle; the block does not
// enforce this. Reset (rst, synchronous) clears the cursor, button history,
// packet phase and both queues, and sets the limits to 80 columns and 24 rows.
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker #(
  parameter int PKT_DEPTH = ps2mt_pkg::PktDepth,
  parameter int RES_DEPTH = ps2mt_pkg::ResDepth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ps2mt_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output ps2mt_pkg::out_item_t out_data,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [7:0]           wr_data
);

  logic                 accept;
  logic                 pkt_valid;
  ps2mt_pkg::pkt_t      pkt_in;
  ps2mt_pkg::pkt_t      pkt_head;
  ps2mt_pkg::q_status_t pkt_status;
  ps2mt_pkg::q_status_t res_status;
  logic                 pkt_take;
  ps2mt_pkg::out_item_t res;

  assign accept = push && !full;
  assign full   = pkt_status.full;
  assign empty  = res_status.empty;

  ps2mt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .pkt_valid (pkt_valid),
    .pkt       (pkt_in)
  );

  ps2mt_fifo #(
    .item_t (ps2mt_pkg::pkt_t),
    .DEPTH  (PKT_DEPTH)
  ) u_pkt_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (pkt_valid),
    .wdata  (pkt_in),
    .rd     (pkt_take),
    .rdata  (pkt_head),
    .status (pkt_status)
  );

  ps2mt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pkt_avail (!pkt_status.empty),
    .pkt       (pkt_head),
    .res_full  (res_status.full),
    .pkt_take  (pkt_take),
    .res       (res)
  );

  ps2mt_fifo #(
    .item_t (ps2mt_pkg::out_item_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr     (pkt_take),
    .wdata  (res),
    .rd     (pop),
    .rdata  (out_data),
    .status (res_status)
  );

endmodule

>>> sv/ps2mt_checker.sv
// Port-level checker for the ps2 mouse packet tracker, bound to the top.
// Depends on ps2mt_pkg and ps2_mouse_packet_tracker_macros.svh.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_macros.svh"

module ps2mt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input ps2mt_pkg::out_item_t out_data
);

  logic taken;
  assign taken = pop && !empty;

  `PS2MT_ASSERT_RESET(a_reset_clear, empty && !full, "queues not clear after reset")
  `PS2MT_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_data),
    "result changed while stalled")
  `PS2MT_ASSERT_SAME(a_cursor_chain, $past(taken) && $past(!rst) && !empty,
    out_data.old_x == $past(out_data.new_x) && out_data.old_y == $past(out_data.new_y),
    "cursor does not continue from previous result")
  `PS2MT_ASSERT_SAME(a_button_chain, $past(taken) && $past(!rst) && !empty,
    out_data.button_changed == (out_data.button_bits ^ $past(out_data.button_bits)),
    "button change mask inconsistent")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for ps2_mouse_packet_tracker: PS/2 mouse reads in, cursor moves out.
// Depends on ps2mt_pkg and the tracker RTL. Checks every move against an in-line cursor predictor.
`timescale 1ns / 1ps

module testbench;
  import ps2mt_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int RandomPhases  = 10;
  localparam int ReadsPerPhase = 153;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       push     = 1'b0;
  logic       full;
  in_item_t   in_data  = '0;
  logic       empty;
  logic       pop      = 1'b0;
  out_item_t  out_data;
  logic       wr_en    = 1'b0;
  logic       wr_index = 1'b0;
  logic [7:0] wr_data  = 8'd0;

  ps2_mouse_packet_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the tracker state
  logic [7:0] width_lim, height_lim;
  logic [7:0] cur_x, cur_y;
  logic [2:0] prev_buttons;
  logic [1:0] pkt_phase;
  logic [7:0] held_buttons, held_dx;

  in_item_t  pending_reads[$];
  out_item_t expected_moves[$];

  bit allow_idle = 1'b1;
  int reads_sent, moves_checked, mismatches, settings_used, cycle_count;
  int send_gap, pop_gap;

  function automatic logic [7:0] clamp_coord(int v, logic [7:0] lim);
    int top;
    // a zero limit behaves like one: only coordinate 0 is legal
    top = (lim == 8'd0) ? 0 : int'(lim) - 1;
    if (v < 0) return 8'd0;
    if (v > top) return top[7:0];
    return v[7:0];
  endfunction

  // advance the packet framing by one accepted request; third byte moves the cursor
  task automatic track_read(in_item_t rd);
    out_item_t mv;
    int dx, dy;
    if (!rd.aux_ready) return;
    if (pkt_phase == ByteDy) begin
      dx = $signed(held_dx);
      dy = $signed(rd.data_byte);
      mv.old_x          = cur_x;
      mv.old_y          = cur_y;
      mv.new_x          = clamp_coord(int'(cur_x) + dx, width_lim);
      mv.new_y          = clamp_coord(int'(cur_y) - dy, height_lim);
      mv.button_bits    = held_buttons[2:0];
      mv.button_changed = held_buttons[2:0] ^ prev_buttons;
      expected_moves.push_back(mv);
      cur_x        = mv.new_x;
      cur_y        = mv.new_y;
      prev_buttons = mv.button_bits;
      pkt_phase    = ByteButtons;
    end else if (pkt_phase == ByteDx) begin
      held_dx   = rd.data_byte;
      pkt_phase = ByteDy;
    end else begin
      held_buttons = rd.data_byte;
      pkt_phase    = ByteDx;
    end
  endtask

  always @(posedge clk) begin : drive_reads
    logic     nxt_push;
    in_item_t nxt_data;
    nxt_push = push;
    nxt_data = in_data;
    if (rst) begin
      nxt_push = 1'b0;
    end else begin
      if (push && !full) begin
        track_read(in_data);
        reads_sent++;
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reads.size() != 0) begin
          if (allow_idle && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 7);
          end else begin
            nxt_data = pending_reads.pop_front();
            nxt_push = 1'b1;
          end
        end
      end
    end
    push    <= nxt_push;
    in_data <= nxt_data;
  end

  always @(posedge clk) begin : check_moves
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected move: old (%0d,%0d) new (%0d,%0d) btn %b chg %b",
                   out_data.old_x, out_data.old_y, out_data.new_x, out_data.new_y,
                   out_data.button_bits, out_data.button_changed);
      end else begin
        want = expected_moves.pop_front();
        moves_checked++;
        if (out_data.old_x !== want.old_x || out_data.old_y !== want.old_y ||
            out_data.new_x !== want.new_x || out_data.new_y !== want.new_y ||
            out_data.button_bits !== want.button_bits ||
            out_data.button_changed !== want.button_changed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("move %0d: expected old (%0d,%0d) new (%0d,%0d) btn %b chg %b",
                     moves_checked, want.old_x, want.old_y, want.new_x, want.new_y,
                     want.button_bits, want.button_changed);
            $display("move %0d:      got old (%0d,%0d) new (%0d,%0d) btn %b chg %b",
                     moves_checked, out_data.old_x, out_data.old_y, out_data.new_x,
                     out_data.new_y, out_data.button_bits, out_data.button_changed);
          end
        end
      end
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 9) == 0) begin
      pop_gap = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_read(logic aux, logic [7:0] data);
    in_item_t rd;
    rd.aux_ready = aux;
    rd.data_byte = data;
    pending_reads.push_back(rd);
  endtask

  // three mouse bytes; with noise, ignored reads may fall between them
  task automatic queue_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, bit noisy);
    queue_read(1'b1, b0);
    if (noisy && $urandom_range(0, 9) == 0) queue_read(1'b0, 8'($urandom));
    queue_read(1'b1, b1);
    if (noisy && $urandom_range(0, 9) == 0) queue_read(1'b0, 8'($urandom));
    queue_read(1'b1, b2);
  endtask

  task automatic write_limit(logic idx, logic [7:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    if (idx == RegWidthLimit) width_lim = val;
    else height_lim = val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // wait until every request is in and every move is out, then let the pipe drain;
  // sampled on the falling edge so the driver's updates have settled
  task automatic settle();
    do @(negedge clk);
    while (pending_reads.size() != 0 || push || expected_moves.size() != 0);
    repeat (8) @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [7:0] rand_delta();
    int v;
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    v = int'($urandom_range(0, 16)) - 8;
    return v[7:0];
  endfunction

  function automatic logic [7:0] rand_limit();
    case ($urandom_range(0, 3))
      0:       return 8'd1;
      1:       return 8'd255;
      2:       return 8'($urandom_range(2, 30));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  initial begin : run_regression
    int n;
    width_lim    = WidthLimitReset;
    height_lim   = HeightLimitReset;
    cur_x        = 8'd0;
    cur_y        = 8'd0;
    prev_buttons = 3'd0;
    pkt_phase    = ByteButtons;
    held_buttons = 8'd0;
    held_dx      = 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset limits: ignored read, zero packet, clamps at both ends, button toggles
    queue_read(1'b0, 8'hA5);
    queue_packet(8'h00, 8'h00, 8'h00, 1'b0);
    queue_packet(8'h07, 8'h7F, 8'h80, 1'b0);
    queue_read(1'b1, 8'h02);
    queue_read(1'b0, 8'hFF);
    queue_read(1'b1, 8'h80);
    queue_read(1'b0, 8'h00);
    queue_read(1'b1, 8'h7F);
    queue_packet(8'hFF, 8'h01, 8'hFF, 1'b0);
    queue_packet(8'hF8, 8'hFF, 8'h01, 1'b0);
    settle();

    // widest field, run to the far corner
    write_limit(RegWidthLimit, 8'd255);
    write_limit(RegHeightLimit, 8'd255);
    queue_packet(8'h01, 8'h7F, 8'h80, 1'b0);
    queue_packet(8'h01, 8'h7F, 8'h80, 1'b0);
    settle();

    // shrink below the cursor: old position reports the stale value
    write_limit(RegWidthLimit, 8'd10);
    write_limit(RegHeightLimit, 8'd5);
    queue_packet(8'h01, 8'h00, 8'h00, 1'b0);
    settle();

    // zero limits pin the cursor to the origin
    write_limit(RegWidthLimit, 8'd0);
    write_limit(RegHeightLimit, 8'd0);
    queue_packet(8'h00, 8'h05, 8'hFB, 1'b0);
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == RandomPhases - 1) allow_idle = 1'b0;
      write_limit(RegWidthLimit, rand_limit());
      write_limit(RegHeightLimit, rand_limit());
      n = 0;
      while (n < ReadsPerPhase) begin
        case ($urandom_range(0, 19))
          0: begin
            // lone mouse byte shifts packet framing
            queue_read(1'b1, 8'($urandom));
            n++;
          end
          1, 2, 3: queue_read(1'b0, 8'($urandom));
          default: begin
            queue_packet(8'($urandom), rand_delta(), rand_delta(), 1'b1);
            n += 3;
          end
        endcase
      end
      settle();
    end

    $display("%0d reads accepted, %0d cursor moves checked", reads_sent, moves_checked);
    $display("%0d limit settings, including 0, 1 and 255, with stalls on both sides",
             settings_used);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/ps2mt_pkg.sv
sv/ps2mt_fifo.sv
sv/ps2mt_front.sv
sv/ps2mt_back.sv
sv/ps2_mouse_packet_tracker.sv
sv/ps2mt_checker.sv
tb/sv/testbench.sv
